// File: hw/rtl/ctab_pkg.sv
package ctab_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SUM_WIDTH   = 48;

  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W    = 48;
  localparam int WEIGHT_W = 32;
  localparam int CMP_W    = (SUM_WIDTH > VAL_W) ? SUM_WIDTH : VAL_W;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [WEIGHT_W-1:0] weight;
    logic [VAL_W-1:0]    random_value;
    logic [VAL_W-1:0]    counter_start;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] content_id;
    logic             is_unique;
    logic             table_error;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     addr;
    logic [SUM_WIDTH-1:0] data;
  } ram_wr_t;

endpackage

// File: hw/rtl/ctab_ram.sv
module ctab_ram
  import ctab_pkg::*;
(
  input  logic                 clk,
  input  ram_wr_t              wr,
  input  logic [IDX_W-1:0]     raddr,
  output logic [SUM_WIDTH-1:0] rdata
);

  logic [SUM_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [SUM_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ctab_ctrl.sv
module ctab_ctrl
  import ctab_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output ram_wr_t              ram_wr,
  output logic [IDX_W-1:0]     ram_raddr,
  input  logic [SUM_WIDTH-1:0] ram_rdata,
  output logic                 res_valid,
  input  logic                 res_ready,
  output out_item_t            res
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SEARCH  = 3'b010,
    ST_DELIVER = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SUM_WIDTH-1:0] total_r, total_nxt;
  logic [VAL_W-1:0]     uniq_r, uniq_nxt;
  logic                 err_r, err_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]     mid_r, mid_nxt;
  logic [VAL_W-1:0]     value_r, value_nxt;
  out_item_t            res_r, res_nxt;

  logic                 accept;
  logic [SUM_WIDTH:0]   new_total;
  logic                 full;
  logic                 hit_top;
  logic                 gt;
  logic [CNT_W-1:0]     lo_s, hi_s, mid_s;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign new_total = {1'b0, total_r} + (SUM_WIDTH+1)'(in_data.weight);
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));
  // last stored sum always equals the running total
  assign hit_top   = (count_r == '0) ||
                     (CMP_W'(in_data.random_value) >= CMP_W'(total_r));

  // one search step per cycle: read data belongs to mid_r
  assign gt    = CMP_W'(ram_rdata) > CMP_W'(value_r);
  assign lo_s  = gt ? lo_r : mid_r + CNT_W'(1);
  assign hi_s  = gt ? mid_r : hi_r;
  assign mid_s = lo_s + ((hi_s - lo_s) >> 1);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    uniq_nxt    = uniq_r;
    err_nxt     = err_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    value_nxt   = value_r;
    res_nxt     = res_r;
    ram_wr.we   = 1'b0;
    ram_wr.addr = count_r[IDX_W-1:0];
    ram_wr.data = new_total[SUM_WIDTH-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_data.cmd))
            CMD_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
              uniq_nxt  = in_data.counter_start;
            end
            CMD_APPEND: begin
              if (full || new_total[SUM_WIDTH]) begin
                err_nxt = 1'b1;
              end else begin
                ram_wr.we = 1'b1;
                total_nxt = new_total[SUM_WIDTH-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_SAMPLE: begin
              res_nxt.table_error = err_r;
              if (hit_top) begin
                res_nxt.content_id = uniq_r;
                res_nxt.is_unique  = 1'b1;
                uniq_nxt           = uniq_r + VAL_W'(1);
                state_nxt          = ST_DELIVER;
              end else begin
                res_nxt.is_unique = 1'b0;
                value_nxt         = in_data.random_value;
                lo_nxt            = '0;
                hi_nxt            = count_r;
                mid_nxt           = count_r >> 1;
                state_nxt         = ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        if (lo_s < hi_s) begin
          mid_nxt = mid_s;
        end else begin
          res_nxt.content_id = VAL_W'(lo_s);
          state_nxt          = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // writes happen only in idle and search reads only after, so no forwarding
  assign ram_raddr = mid_nxt[IDX_W-1:0];
  assign res_valid = (state_r == ST_DELIVER);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      total_r <= '0;
      uniq_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      uniq_r  <= uniq_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    value_r <= value_nxt;
    res_r   <= res_nxt;
  end

endmodule

// File: hw/rtl/cumulative_table_sampler_top.sv
// Cumulative table sampler.
// Input channel in_valid/in_ready/in_data carries one request: clear (empty
// the table, load the unique counter), append (add a weight, store the new
// running sum) or sample (draw an entry for a random value). Only a sample
// gives a result, on out_valid/out_ready/out_data.
// Clear, append and unused commands are handled in the idle state itself.
// A sample that falls at or above the last sum, or hits an empty table,
// returns the unique counter without a search.
// Otherwise a binary search runs over the sum table, one synchronous RAM
// read per step, ceil(log2(entries + 1)) steps: up to 11 for a full 1024
// entry table.
// The next request is taken once the current result is handed to the
// output register; that register lets a new request be accepted while the
// previous result still waits for out_ready.
// If the receiver stalls with a result held, a further sample waits in the
// controller until the output register frees.
// Reset (rst_n low, synchronous) empties the table, zeroes the running
// total and the unique counter and clears the sticky error flag.
module cumulative_table_sampler_top
  import ctab_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ram_wr_t              ram_wr;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SUM_WIDTH-1:0] ram_rdata;
  logic                 res_valid;
  logic                 res_ready;
  out_item_t            res;

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r;

  ctab_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ctab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
